@@ sv/lpe_pkg.sv @@
// ---------------------------------------------------------------------------
// lpe_pkg - shared types and constants for the lagrange evaluator
// Node store depth, field widths and the status codes.
// ---------------------------------------------------------------------------
package lpe_pkg;

  localparam int MaxNodes  = 8;
  localparam int IdxW      = $clog2(MaxNodes);
  localparam int TermW     = 60;
  localparam int ProdW     = 93;   // 60 x 33 magnitude product
  localparam int DivW      = 96;   // dividend width, shifted up by one
  localparam int CntW      = 7;
  localparam int DivCells  = 4;    // division cells walked per cycle
  localparam int DivPasses = DivW / DivCells;

  localparam logic [TermW-2:0] TermLimit = '1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DUP = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  // step request handed from the sequencer to the step unit
  typedef struct packed {
    logic                 start;
    logic signed [TermW-1:0] t;
    logic signed [32:0]   num;
    logic signed [32:0]   den;
  } step_req_t;

  typedef struct packed {
    logic                 done;
    logic                 sat;
    logic signed [TermW-1:0] t;
  } step_rsp_t;

endpackage

@@ sv/lpe_div_cell.sv @@
// ---------------------------------------------------------------------------
// lpe_div_cell - one restoring-division cell
// Takes partial remainder and quotient from its left neighbour, shifts in one
// dividend bit, compares against the doubled divisor and passes on.
// ---------------------------------------------------------------------------
module lpe_div_cell (
  input  logic [lpe_pkg::DivW-1:0]  rem_in,
  input  logic [lpe_pkg::DivW-1:0]  quo_in,
  input  logic [lpe_pkg::DivW-1:0]  dvd_in,
  input  logic [lpe_pkg::DivW-1:0]  dd,
  output logic [lpe_pkg::DivW-1:0]  rem_out,
  output logic [lpe_pkg::DivW-1:0]  quo_out,
  output logic [lpe_pkg::DivW-1:0]  dvd_out
);

  logic [lpe_pkg::DivW-1:0] sh;
  logic                     ge;

  // shift in next dividend bit and trial subtract
  always_comb begin
    sh      = {rem_in[lpe_pkg::DivW-2:0], dvd_in[lpe_pkg::DivW-1]};
    ge      = (sh >= dd);
    rem_out = ge ? sh - dd : sh;
    quo_out = {quo_in[lpe_pkg::DivW-2:0], ge};
    dvd_out = {dvd_in[lpe_pkg::DivW-2:0], 1'b0};
  end

endmodule

@@ sv/lpe_step_unit.sv @@
// ---------------------------------------------------------------------------
// lpe_step_unit - one scaling step t * num / den, rounded
// Multiplies magnitudes in 63-bit partial products, then runs a row of
// division cells over the 96-bit dividend, four cells per cycle.
// ---------------------------------------------------------------------------
module lpe_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  lpe_pkg::step_req_t req,
  output lpe_pkg::step_rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } st_t;

  st_t st_r;
  logic [4:0]                     cnt_r;
  logic                           neg_r;
  logic [59:0]                    tmag_r;
  logic [32:0]                    nm_r;
  logic [32:0]                    dm_r;
  logic [lpe_pkg::ProdW-1:0]      prod_r;
  logic [lpe_pkg::ProdW-1:0]      prod_w;
  logic [lpe_pkg::DivW-1:0]       rem_r, quo_r, dvd_r, dd_r;
  logic [lpe_pkg::DivW-1:0]       rem_c [lpe_pkg::DivCells+1];
  logic [lpe_pkg::DivW-1:0]       quo_c [lpe_pkg::DivCells+1];
  logic [lpe_pkg::DivW-1:0]       dvd_c [lpe_pkg::DivCells+1];
  logic                           sat_w;
  logic [lpe_pkg::TermW-1:0]      qv_w;
  logic [29:0]                    thalf_w;
  logic [62:0]                    pp_w;
  logic [lpe_pkg::TermW-1:0]      tabs_w;

  assign tabs_w = req.t[lpe_pkg::TermW-1] ? -req.t : req.t;

  // magnitude product, low half of t first, then the high half shifted up by 30
  assign thalf_w = cnt_r[0] ? tmag_r[59:30] : tmag_r[29:0];
  assign pp_w    = 63'(thalf_w) * 63'(nm_r);
  assign prod_w  = prod_r + {pp_w, 30'b0};

  // chain of division cells; the last stage registers back into the first
  assign rem_c[0] = rem_r;
  assign quo_c[0] = quo_r;
  assign dvd_c[0] = dvd_r;
  for (genvar g = 0; g < lpe_pkg::DivCells; g++) begin : g_cell
    lpe_div_cell u_cell (
      .rem_in  (rem_c[g]),
      .quo_in  (quo_c[g]),
      .dvd_in  (dvd_c[g]),
      .dd      (dd_r),
      .rem_out (rem_c[g+1]),
      .quo_out (quo_c[g+1]),
      .dvd_out (dvd_c[g+1])
    );
  end

  // saturate quotient to the term bound
  assign sat_w = (quo_r[lpe_pkg::DivW-1:lpe_pkg::TermW-1] != '0);
  assign qv_w  = sat_w ? {1'b0, lpe_pkg::TermLimit} : quo_r[lpe_pkg::TermW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (st_r == S_FIN);
      unique case (st_r)
        S_IDLE: begin
          if (req.start) begin
            neg_r  <= req.t[lpe_pkg::TermW-1] ^ req.num[32] ^ req.den[32];
            tmag_r <= tabs_w;
            nm_r   <= req.num[32] ? -req.num : req.num;
            dm_r   <= req.den[32] ? -req.den : req.den;
            cnt_r  <= '0;
            prod_r <= '0;
            st_r   <= S_MUL;
          end
        end
        S_MUL: begin
          if (!cnt_r[0]) begin
            prod_r <= {30'b0, pp_w};
            cnt_r  <= 5'd1;
          end else begin
            prod_r <= prod_w;
            cnt_r  <= '0;
            st_r   <= S_DIV;
            rem_r  <= '0;
            quo_r  <= '0;
            dd_r   <= {62'b0, dm_r, 1'b0};
            dvd_r  <= {2'b0, prod_w, 1'b0} + {63'b0, dm_r};
          end
        end
        S_DIV: begin
          rem_r <= rem_c[lpe_pkg::DivCells];
          quo_r <= quo_c[lpe_pkg::DivCells];
          dvd_r <= dvd_c[lpe_pkg::DivCells];
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(lpe_pkg::DivPasses-1)) st_r <= S_FIN;
        end
        S_FIN: begin
          rsp.sat  <= sat_w;
          rsp.t    <= neg_r ? -qv_w : qv_w;
          st_r     <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // a finished step is reported only from the final state
  assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(st_r) == S_FIN) else $error("step done out of order");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> dd_r != '0 || dm_r == '0) else $error("divisor lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |=> (st_r == S_DIV || st_r == S_FIN)) else $error("bad div exit");

endmodule

@@ sv/lagrange_polynomial_eval_unit.sv @@
// ---------------------------------------------------------------------------
// lagrange_polynomial_eval_unit - Lagrange interpolation in signed Q16.16
// Node store, duplicate check, per-term scaling chain and saturating sum.
// ---------------------------------------------------------------------------
//  channel | dir | tdata / data fields (low bit first)
//  in_     | in  | node_index[2:0], node_x[34:3], node_y[66:35], query_x[98:67];
//          |     | tuser = command
//  out_    | out | value[31:0], status[33:32]
//  cfg_    | in  | degree_used[2:0]
//
//  a load is taken while idle; an evaluate holds in_tready low while node pairs
//  are compared for a duplicate abscissa and while the scaling steps of every
//  term run, all of them on the shared multiply/divide step unit
//  a finished result waits in the output register; while it is still held the
//  next evaluate stalls on its last cycle; rst_n synchronous, sets degree_used to 1
//  out_tvalid holds with its data until out_tready
// ---------------------------------------------------------------------------
module lagrange_polynomial_eval_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // node_index, node_x, node_y, query_x
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // value, status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data    // degree_used in low 3 bits
);

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_DUP  = 5'b00010,
    E_TERM = 5'b00100,
    E_WAIT = 5'b01000,
    E_SUM  = 5'b10000
  } est_t;

  est_t est_r;
  logic [2:0]  deg_r;
  logic [31:0] xs_r [lpe_pkg::MaxNodes];
  logic [31:0] ys_r [lpe_pkg::MaxNodes];
  logic [31:0] qx_r;
  logic [2:0]  i_r, j_r;
  logic        sat_r, go_r;
  logic signed [lpe_pkg::TermW-1:0] t_r;
  logic signed [63:0] sum_r;
  logic signed [63:0] t_ext;
  logic signed [63:0] sum_fin;
  logic [31:0] val_r;
  logic [1:0]  stat_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic        out_free;
  logic        dup_hit;
  logic        res_load;
  lpe_pkg::step_req_t req;
  lpe_pkg::step_rsp_t rsp;
  logic        in_acc;

  assign in_tready  = (est_r == E_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, stat_r, val_r};

  assign req.start = go_r;
  assign req.t     = t_r;
  assign req.num   = {qx_r[31], qx_r} - {xs_r[j_r][31], xs_r[j_r]};
  assign req.den   = {xs_r[i_r][31], xs_r[i_r]} - {xs_r[j_r][31], xs_r[j_r]};

  // signed term extension and final sum
  assign t_ext   = {{4{t_r[59]}}, t_r};
  assign sum_fin = sum_r + t_ext;

  // output register control
  assign out_free    = !out_vld_r || out_tready;
  assign dup_hit     = (deg_r != 3'd0) && (xs_r[i_r] == xs_r[j_r]);
  assign res_load    = out_free && ((est_r == E_DUP && dup_hit) ||
                                    (est_r == E_SUM && i_r == deg_r));
  assign out_vld_nxt = res_load || (out_vld_r && !out_tready);

  lpe_step_unit u_step (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // node store writes
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == lpe_pkg::CMD_LOAD) begin
      xs_r[in_tdata[2:0]] <= in_tdata[34:3];
      ys_r[in_tdata[2:0]] <= in_tdata[66:35];
    end
  end

  // evaluation sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r     <= E_IDLE;
      deg_r     <= 3'd1;
      go_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      go_r      <= (est_r == E_TERM) && (j_r != i_r);
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) deg_r <= cfg_data[2:0];
      unique case (est_r)
        E_IDLE: begin
          if (in_acc && in_tuser == lpe_pkg::CMD_EVAL) begin
            qx_r  <= in_tdata[98:67];
            i_r   <= '0;
            j_r   <= 3'd1;
            est_r <= E_DUP;
          end
        end
        // pairwise abscissa compare, one pair a cycle while no duplicate waits on the output register
        E_DUP: begin
          if (deg_r == 3'd0 || xs_r[i_r] == xs_r[j_r] || (i_r == deg_r - 3'd1 && j_r == deg_r))
          begin
            if (dup_hit) begin
              if (out_free) begin
                val_r  <= '0;
                stat_r <= lpe_pkg::ST_DUP;
                est_r  <= E_IDLE;
              end
            end else begin
              i_r   <= '0;
              j_r   <= '0;
              sum_r <= '0;
              sat_r <= 1'b0;
              t_r   <= {{28{ys_r[0][31]}}, ys_r[0]};
              est_r <= E_TERM;
            end
          end else if (j_r == deg_r) begin
            i_r <= i_r + 3'd1;
            j_r <= i_r + 3'd2;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        // walk j for term i, skipping j == i
        E_TERM: begin
          if (j_r == i_r && j_r != deg_r) begin
            j_r <= j_r + 3'd1;
          end else if (j_r == i_r) begin
            est_r <= E_SUM;
          end else begin
            est_r <= E_WAIT;
          end
        end
        E_WAIT: begin
          if (rsp.done) begin
            t_r   <= rsp.t;
            sat_r <= sat_r | rsp.sat;
            if (j_r == deg_r) est_r <= E_SUM;
            else begin
              j_r   <= j_r + 3'd1;
              est_r <= E_TERM;
            end
          end
        end
        E_SUM: begin
          if (i_r == deg_r) begin
            if (out_free) begin
              est_r <= E_IDLE;
              if (sat_r || sum_fin > 64'sd2147483647 || sum_fin < -64'sd2147483648) begin
                stat_r <= lpe_pkg::ST_OVF;
                val_r  <= (sum_fin < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
              end else begin
                stat_r <= lpe_pkg::ST_OK;
                val_r  <= sum_fin[31:0];
              end
            end
          end else begin
            sum_r <= sum_fin;
            i_r   <= i_r + 3'd1;
            j_r   <= '0;
            t_r   <= {{28{ys_r[i_r + 3'd1][31]}}, ys_r[i_r + 3'd1]};
            est_r <= E_TERM;
          end
        end
        default: est_r <= E_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> est_r == E_IDLE) else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> j_r != i_r) else $error("self ratio issued");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> stat_r != 2'd3) else $error("bad status");

endmodule
